>>> rtl/qpdf_pkg.sv
`default_nettype none

package qpdf_pkg;

  localparam int NUM_CH      = 5;
  localparam int PCT_W       = 7;
  localparam int DUTY_W      = 16;
  localparam int PERIOD_W    = 16;
  localparam int COUNT_W     = 7;
  localparam int PCT_SET_W   = NUM_CH * PCT_W;
  localparam int IN_DATA_W   = ((PCT_SET_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = NUM_CH * DUTY_W + 3 + COUNT_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // pct * period stays below 100 * 2^16 < 2^23
  localparam int PROD_W      = 23;
  // floor(x / 100) = (x * ceil(2^30 / 100)) >> 30, exact for x < 2^23
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;
  localparam int SCALED_W    = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

  localparam logic [PCT_W-1:0]    PCT_MAX      = 7'd100;
  localparam logic [DUTY_W-1:0]   SNAP_DIST    = 16'd20;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

  typedef logic [PCT_W-1:0]  pct_t;
  typedef logic [DUTY_W-1:0] duty_t;
  typedef pct_t  [NUM_CH-1:0] pct_set_t;
  typedef duty_t [NUM_CH-1:0] duty_set_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/qpdf_queue.sv
`default_nettype none

module qpdf_queue
  import qpdf_pkg::*;
#(
  parameter int DEPTH = 80,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire q_ctrl_t          ctrl,
  input  wire pct_set_t         wdata,
  output logic      [CNT_W-1:0] used,
  output pct_set_t              head
);

  pct_set_t mem [DEPTH];

  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W-1:0] wptr_inc;
  logic [PTR_W-1:0] rptr_inc;
  logic [PTR_W-1:0] rptr_next;

  pct_set_t rd_data;
  pct_set_t byp_data;
  logic     byp_hit;

  assign wptr_inc  = (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
  assign rptr_inc  = (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
  assign rptr_next = ctrl.pop ? rptr_inc : rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (ctrl.push) wptr <= wptr_inc;
      rptr <= rptr_next;
      used <= used + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);
    end
  end

  // head entry is prefetched at the next read address every cycle
  always_ff @(posedge clk) begin
    if (ctrl.push) mem[wptr] <= wdata;
    rd_data  <= mem[rptr_next];
    byp_hit  <= ctrl.push && (wptr == rptr_next);
    byp_data <= wdata;
  end

  assign head = byp_hit ? byp_data : rd_data;

endmodule

`default_nettype wire

>>> rtl/qpdf_scale.sv
`default_nettype none

module qpdf_scale
  import qpdf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire pct_set_t            pcts,
  input  wire logic [PERIOD_W-1:0] period,
  output duty_set_t                target,
  output logic                     busy
);

  logic [PROD_W-1:0]   prod   [NUM_CH];
  logic [SCALED_W-1:0] scaled [NUM_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  // stage one: pct * period
  always_ff @(posedge clk) begin
    if (start) begin
      for (int c = 0; c < NUM_CH; c++) begin
        prod[c] <= PROD_W'(pcts[c]) * PROD_W'(period);
      end
    end
  end

  // stage two: divide by 100 through the reciprocal
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      scaled[c] = SCALED_W'(prod[c]) * SCALED_W'(RECIP_100);
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      for (int c = 0; c < NUM_CH; c++) begin
        target[c] <= scaled[c][RECIP_SHIFT +: DUTY_W];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/qpdf_fade.sv
`default_nettype none

module qpdf_fade
  import qpdf_pkg::*;
(
  input  wire duty_set_t applied,
  input  wire duty_set_t target,
  output duty_set_t      duty_next,
  output logic           done,
  output logic           zero
);

  always_comb begin
    logic [DUTY_W+2:0] sum;
    logic [DUTY_W-1:0] d;
    logic [DUTY_W-1:0] diff;
    done = 1'b1;
    zero = 1'b1;
    for (int c = 0; c < NUM_CH; c++) begin
      // 7 * duty + target, then >> 3
      sum  = {applied[c], 3'b000} - (DUTY_W+3)'(applied[c]) + (DUTY_W+3)'(target[c]);
      d    = sum[DUTY_W+2:3];
      diff = (d < target[c]) ? (target[c] - d) : (d - target[c]);
      duty_next[c] = (diff < SNAP_DIST) ? target[c] : d;
      if (duty_next[c] != target[c]) done = 1'b0;
      if (duty_next[c] != '0) zero = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/queued_pwm_duty_fader.sv
// five-channel led duty fader with a queue of target sets
// s_tuser selects the request: 0 is a fade tick, 1 queues five percentages
// carried in s_tdata; a set with any percentage above 100 or a full queue
// is rejected and leaves all state unchanged.
// every accepted request gives one result on the m_ side: the five applied
// duties, fade_active, set_accepted, lights_off and the queue fill count.
// the result is registered: it is valid in the cycle after the request is accepted.
// throughput: one request per cycle unless the output is held; loading a new
// target set drops s_tready for a single cycle while the second stage of the
// pct * period / 100 scaling (two registered multiplier stages) completes.
// the pwm period is written through cfg_valid/cfg_data and takes effect when
// a target set is loaded from the queue.
// reset clears the queue, the duties, the fade and lights-off flags and sets
// the pwm period to 1000; the queue storage itself is not cleared.
// the output register is the only buffer: while m_tready is low with a result
// waiting, s_tready stays low and no further request is taken.
`default_nettype none

module queued_pwm_duty_fader
  import qpdf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 80
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // cool_white_pct, warm_white_pct, red_pct, green_pct, blue_pct, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // operation
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // cool_white_duty, warm_white_duty, red_duty, green_duty, blue_duty,
  // fade_active, set_accepted, lights_off, queue_count, zero pad
  output logic [OUT_DATA_W-1:0]      m_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [PERIOD_W-1:0]   cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [PERIOD_W-1:0] period;
  duty_set_t           applied;
  logic                fading;
  logic                sleep_flag;

  pct_set_t   in_pcts;
  logic       accept;
  logic       is_set;
  logic       pct_ok;
  logic       push;
  logic       tick;
  logic       pop;
  logic       fading_mid;
  logic       fading_next;
  logic       sleep_next;
  duty_set_t  applied_next;
  duty_set_t  fade_duty;
  logic       fade_done;
  logic       fade_zero;
  pct_set_t   pop_pcts;
  q_ctrl_t    q_ctrl;

  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] used_next;
  pct_set_t         head;
  duty_set_t        target;
  logic             scale_busy;

  assign in_pcts   = pct_set_t'(s_tdata[PCT_SET_W-1:0]);
  assign s_tready  = !scale_busy && (!m_tvalid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    pct_ok = 1'b1;
    for (int c = 0; c < NUM_CH; c++) begin
      if (in_pcts[c] > PCT_MAX) pct_ok = 1'b0;
    end
  end

  assign is_set = (op_t'(s_tuser) == OP_SET);
  assign push   = is_set && pct_ok && (used != CNT_W'(QUEUE_DEPTH));
  assign tick   = !is_set && fading;

  qpdf_fade u_fade (
    .applied   (applied),
    .target    (target),
    .duty_next (fade_duty),
    .done      (fade_done),
    .zero      (fade_zero)
  );

  assign fading_mid   = (tick && fade_done) ? 1'b0 : fading;
  assign sleep_next   = sleep_flag || (tick && fade_done && fade_zero);
  assign applied_next = tick ? fade_duty : applied;

  // an empty queue pops the entry that this request just pushed
  assign pop         = !fading_mid && ((used != '0) || push);
  assign pop_pcts    = (used == '0) ? in_pcts : head;
  assign fading_next = fading_mid || pop;
  assign used_next   = used + CNT_W'(push) - CNT_W'(pop);

  assign q_ctrl.push = accept && push;
  assign q_ctrl.pop  = accept && pop;

  qpdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (q_ctrl),
    .wdata (in_pcts),
    .used  (used),
    .head  (head)
  );

  qpdf_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (q_ctrl.pop),
    .pcts   (pop_pcts),
    .period (period),
    .target (target),
    .busy   (scale_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      applied    <= '0;
      fading     <= 1'b0;
      sleep_flag <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        applied    <= applied_next;
        fading     <= fading_next;
        sleep_flag <= sleep_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {(OUT_DATA_W - OUT_FIELD_W)'(0), COUNT_W'(used_next), sleep_next, push,
                  fading_next, applied_next};
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/qpdf_fade_checker.sv
`timescale 1ns / 100ps

module qpdf_fade_checker
  import qpdf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 80
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  // cool_white_pct, warm_white_pct, red_pct, green_pct, blue_pct, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // operation
  input  wire logic                  s_tuser,
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  // cool_white_duty, warm_white_duty, red_duty, green_duty, blue_duty,
  // fade_active, set_accepted, lights_off, queue_count, zero pad
  input  wire logic [OUT_DATA_W-1:0] m_tdata,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [PERIOD_W-1:0]   cfg_data,
  output int                         mismatches,
  output int                         awaiting
);

  // same layout as m_tdata, first member in the top bits
  typedef struct packed {
    logic [OUT_DATA_W-OUT_FIELD_W-1:0] pad;
    logic [COUNT_W-1:0]                queue_count;
    logic                              lights_off;
    logic                              set_accepted;
    logic                              fade_active;
    duty_set_t                         duties;
  } fader_status_t;

  string duty_name [NUM_CH] = '{"cool_white_duty", "warm_white_duty", "red_duty",
                                "green_duty", "blue_duty"};

  pct_set_t             set_store [QUEUE_DEPTH];
  int unsigned          wr_ptr;
  int unsigned          rd_ptr;
  int unsigned          sets_waiting;
  duty_set_t            target;
  duty_set_t            applied;
  bit                   fading;
  bit                   lights_out;
  logic [PERIOD_W-1:0]  period;
  fader_status_t        awaited_status [$];

  function automatic void load_next_set();
    int c;
    int unsigned prod;
    if (fading || sets_waiting == 0) return;
    for (c = 0; c < NUM_CH; c++) begin
      prod = set_store[rd_ptr][c] * period;
      target[c] = duty_t'(prod / PCT_MAX);
    end
    rd_ptr = (rd_ptr + 1 >= QUEUE_DEPTH) ? 0 : rd_ptr + 1;
    sets_waiting--;
    fading = 1'b1;
  endfunction

  function automatic void fade_step();
    int c;
    int unsigned d;
    int unsigned t;
    int unsigned diff;
    bit done;
    bit all_zero;
    done = 1'b1;
    all_zero = 1'b1;
    if (!fading) return;
    for (c = 0; c < NUM_CH; c++) begin
      t = target[c];
      d = (applied[c] * 7 + t) >> 3;
      diff = (d < t) ? t - d : d - t;
      if (diff < SNAP_DIST) d = t;
      applied[c] = duty_t'(d);
      if (applied[c] != t) done = 1'b0;
      if (applied[c] != '0) all_zero = 1'b0;
    end
    if (done) begin
      fading = 1'b0;
      if (all_zero) lights_out = 1'b1;
    end
  endfunction

  function automatic fader_status_t apply_request(op_t op, pct_set_t p);
    fader_status_t r;
    bit took;
    int c;
    r = '0;
    took = 1'b0;
    if (op == OP_SET) begin
      took = sets_waiting < QUEUE_DEPTH;
      for (c = 0; c < NUM_CH; c++)
        if (p[c] > PCT_MAX) took = 1'b0;
      if (took) begin
        set_store[wr_ptr] = p;
        wr_ptr = (wr_ptr + 1 >= QUEUE_DEPTH) ? 0 : wr_ptr + 1;
        sets_waiting++;
      end
    end else begin
      fade_step();
    end
    load_next_set();
    r.duties       = applied;
    r.fade_active  = fading;
    r.set_accepted = took;
    r.lights_off   = lights_out;
    r.queue_count  = COUNT_W'(sets_waiting);
    return r;
  endfunction

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  initial mismatches = 0;

  always @(posedge clk) begin
    fader_status_t got;
    fader_status_t want;
    int c;
    if (rst) begin
      wr_ptr = 0;
      rd_ptr = 0;
      sets_waiting = 0;
      target = '0;
      applied = '0;
      fading = 1'b0;
      lights_out = 1'b0;
      period = PERIOD_RESET;
      awaited_status.delete();
    end else begin
      if (cfg_valid && cfg_ready) period = cfg_data;
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (awaited_status.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none, got %h", $time, m_tdata);
        end else begin
          want = awaited_status.pop_front();
          for (c = 0; c < NUM_CH; c++)
            compare_field(duty_name[c], want.duties[c], got.duties[c]);
          compare_field("fade_active", want.fade_active, got.fade_active);
          compare_field("set_accepted", want.set_accepted, got.set_accepted);
          compare_field("lights_off", want.lights_off, got.lights_off);
          compare_field("queue_count", want.queue_count, got.queue_count);
        end
      end
      // compare before predicting: a result never leaves in its own request's cycle
      if (s_tvalid && s_tready)
        awaited_status.push_back(apply_request(op_t'(s_tuser), s_tdata[PCT_SET_W-1:0]));
    end
    awaiting = awaited_status.size();
  end

endmodule

>>> tb/sv/queued_pwm_duty_fader_tb.sv
`timescale 1ns / 100ps

module queued_pwm_duty_fader_tb;
  import qpdf_pkg::*;

  localparam int QUEUE_DEPTH    = 80;
  localparam int LONG_HOLD      = 400;
  localparam int CFG_SETTLE     = 4;
  localparam int END_SETTLE     = 10;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [PERIOD_W-1:0]   cfg_data = '0;

  int mismatches;
  int awaiting;
  int results_seen = 0;
  int quiet_cycles = 0;
  int mode_left = 0;
  bit send_bursty = 1'b0;
  bit sink_bursty = 1'b0;
  bit squeezed = 1'b0;

  queued_pwm_duty_fader #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  qpdf_fade_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .awaiting  (awaiting)
  );

  always #4 clk = ~clk;

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic pct_set_t pct_row(int cw, int ww, int rd, int gr, int bl);
    pct_set_t p;
    p[0] = pct_t'(cw);
    p[1] = pct_t'(ww);
    p[2] = pct_t'(rd);
    p[3] = pct_t'(gr);
    p[4] = pct_t'(bl);
    return p;
  endfunction

  // mostly valid percentages, now and then one channel out of range
  function automatic pct_set_t random_pcts(int reject_odds);
    pct_set_t p;
    int c;
    for (c = 0; c < NUM_CH; c++) begin
      case ($urandom_range(0, 3))
        0: p[c] = '0;
        1: p[c] = PCT_MAX;
        default: p[c] = pct_t'($urandom_range(0, 100));
      endcase
    end
    if ($urandom_range(1, reject_odds) == 1)
      p[$urandom_range(0, NUM_CH - 1)] = pct_t'($urandom_range(101, 127));
    return p;
  endfunction

  // switch between stretches with and without idling
  always @(negedge clk) begin
    if (mode_left == 0) begin
      mode_left   <= $urandom_range(30, 150);
      send_bursty <= $urandom_range(0, 2) != 0;
      sink_bursty <= $urandom_range(0, 2) != 0;
    end else begin
      mode_left <= mode_left - 1;
    end
  end

  always @(posedge clk)
    if (m_tvalid && m_tready) results_seen <= results_seen + 1;

  initial begin : result_sink
    int quiet;
    quiet = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!squeezed && s_tvalid && results_seen >= 200) begin
        // long hold-off so the output register fills and input backs up
        squeezed = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        if (quiet > 0) begin
          m_tready <= 1'b0;
          quiet--;
        end else if (sink_bursty && $urandom_range(0, 3) == 0) begin
          m_tready <= 1'b0;
          quiet = gap_len() - 1;
        end else begin
          m_tready <= 1'b1;
        end
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic offer(input op_t op, input pct_set_t p);
    if (send_bursty && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    if (op == OP_SET)
      s_tdata <= IN_DATA_W'(p);
    else
      s_tdata <= IN_DATA_W'(PCT_SET_W'({$urandom(), $urandom()}));
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    s_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    // let a target load still in the scaler finish first
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_mix(input int count);
    op_t op;
    repeat (count) begin
      op = OP_SET;
      if ($urandom_range(0, 99) < 60) op = OP_TICK;
      offer(op, random_pcts(12));
    end
  endtask

  // tiny targets so fades between sets end in one tick; sets past the queue depth, then ticks
  task automatic fill_then_drain();
    repeat (QUEUE_DEPTH + 4) offer(OP_SET, random_pcts(10));
    repeat (QUEUE_DEPTH + 4) offer(OP_TICK, '0);
  endtask

  initial begin : stimulus
    pct_set_t p;
    int c;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    offer(OP_TICK, '0);                                 // tick with nothing to do
    offer(OP_SET, pct_row(0, 0, 0, 0, 0));              // loads targets equal to duties
    offer(OP_TICK, '0);                                 // fade ends at zero: lights off
    offer(OP_SET, pct_row(100, 100, 100, 100, 100));
    offer(OP_SET, pct_row(0, 100, 50, 1, 99));          // waits behind the running fade
    for (c = 0; c < NUM_CH; c++) begin
      p = pct_row(50, 50, 50, 50, 50);
      p[c] = (c % 2 == 0) ? pct_t'(101) : pct_t'(127);
      offer(OP_SET, p);
    end
    offer(OP_SET, pct_row(100, 0, 100, 0, 100));
    repeat (10) offer(OP_TICK, '0);

    write_period(16'hFFFF);
    random_mix(120);
    write_period(16'd1);
    fill_then_drain();
    write_period(16'd0);
    random_mix(60);
    write_period(PERIOD_W'($urandom_range(2, 65534)));
    random_mix(150);
    write_period(16'd37);
    random_mix(80);
    write_period(PERIOD_RESET);
    random_mix(80);

    s_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (END_SETTLE) @(negedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
